@@ hw/rtl/tclp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types, codes and keyword tables of the command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

    localparam int MAX_LINE = 4096;
    localparam int POS_W    = $clog2(MAX_LINE + 1);
    localparam int OFF_W    = $clog2(MAX_LINE);
    localparam int NUM_KW   = 11;
    localparam int NLEN_W   = 4;

    localparam int OUT_OFF_W = 12;
    localparam int OUT_LEN_W = 13;

    localparam logic [NUM_KW-1:0] ALL_KW = {NUM_KW{1'b1}};

    localparam logic [1:0] ROLE_NONE  = 2'd0;
    localparam logic [1:0] ROLE_NAME  = 2'd1;
    localparam logic [1:0] ROLE_KEY   = 2'd2;
    localparam logic [1:0] ROLE_VALUE = 2'd3;

    localparam logic [3:0] CMD_SET      = 4'd0;
    localparam logic [3:0] CMD_GET      = 4'd1;
    localparam logic [3:0] CMD_DELETE   = 4'd2;
    localparam logic [3:0] CMD_EXISTS   = 4'd3;
    localparam logic [3:0] CMD_KEYS     = 4'd4;
    localparam logic [3:0] CMD_CLEAR    = 4'd5;
    localparam logic [3:0] CMD_BEGIN    = 4'd6;
    localparam logic [3:0] CMD_COMMIT   = 4'd7;
    localparam logic [3:0] CMD_ROLLBACK = 4'd8;
    localparam logic [3:0] CMD_HELP     = 4'd9;
    localparam logic [3:0] CMD_EXIT     = 4'd10;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EMPTY     = 3'd1;
    localparam logic [2:0] ST_UNKNOWN   = 3'd2;
    localparam logic [2:0] ST_NO_KEY    = 3'd3;
    localparam logic [2:0] ST_NO_VALUE  = 3'd4;
    localparam logic [2:0] ST_EXTRA     = 3'd5;
    localparam logic [2:0] ST_TOO_LONG  = 3'd6;

    // keyword text, right-aligned, lower case
    localparam logic [63:0] KW_TEXT [NUM_KW] = '{
        64'("set"), 64'("get"), 64'("delete"), 64'("exists"), 64'("keys"),
        64'("clear"), 64'("begin"), 64'("commit"), 64'("rollback"),
        64'("help"), 64'("exit")
    };

    localparam logic [NLEN_W-1:0] KW_LEN [NUM_KW] = '{
        4'd3, 4'd3, 4'd6, 4'd6, 4'd4, 4'd5, 4'd5, 4'd6, 4'd8, 4'd4, 4'd4
    };

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       line_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           byte_role;
        logic [OUT_OFF_W-1:0] byte_offset;
        logic                 line_done;
        logic [3:0]           command_code;
        logic [2:0]           parse_status;
        logic [OUT_OFF_W-1:0] key_start;
        logic [OUT_LEN_W-1:0] key_length;
        logic [OUT_OFF_W-1:0] value_start;
        logic [OUT_LEN_W-1:0] value_length;
    } out_item_t;

    function automatic logic [NUM_KW-1:0] kw_len_mask(input logic [NLEN_W-1:0] nlen);
        logic [NUM_KW-1:0] m;
        m = '0;
        for (int k = 0; k < NUM_KW; k++)
        begin
            m[k] = (KW_LEN[k] == nlen);
        end
        return m;
    endfunction

    function automatic logic [3:0] cmd_of(input logic [NUM_KW-1:0] cand);
        logic [3:0] c;
        c = CMD_SET;
        for (int k = NUM_KW - 1; k >= 0; k--)
        begin
            if (cand[k])
            begin
                c = 4'(k);
            end
        end
        return c;
    endfunction

endpackage

@@ hw/rtl/tclp_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_in_if
// Input channel of the command line parser: at most one line byte per item.
// ----------------------------------------------------------------------------
interface tclp_in_if;
    logic               valid;
    logic               ready;
    tclp_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tclp_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_out_if
// Result channel of the command line parser: one result item per input item.
// ----------------------------------------------------------------------------
interface tclp_out_if;
    logic                valid;
    logic                ready;
    tclp_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/tclp_kw_match.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tclp_kw_match
// Narrows the keyword candidate set by one command name byte, ignoring case.
// ----------------------------------------------------------------------------
module tclp_kw_match
(
    input  logic [tclp_pkg::NUM_KW-1:0] cand,
    input  logic [tclp_pkg::NLEN_W-1:0] name_len,
    input  logic [7:0]                  byte_value,
    output logic [tclp_pkg::NUM_KW-1:0] cand_step
);

    logic [7:0] folded;
    logic [2:0] sel;
    logic [7:0] kw_ch;

    assign folded = (byte_value >= 8'd65 && byte_value <= 8'd90) ? byte_value + 8'd32
                                                                 : byte_value;

    always_comb
    begin
        cand_step = cand;
        sel       = '0;
        kw_ch     = '0;
        for (int k = 0; k < tclp_pkg::NUM_KW; k++)
        begin
            if (name_len >= tclp_pkg::KW_LEN[k])
            begin
                cand_step[k] = 1'b0;
            end
            else
            begin
                sel   = 3'(tclp_pkg::KW_LEN[k] - name_len - 4'd1);
                kw_ch = tclp_pkg::KW_TEXT[k][{sel, 3'b000} +: 8];
                if (kw_ch != folded)
                begin
                    cand_step[k] = 1'b0;
                end
            end
        end
    end

endmodule

@@ hw/rtl/text_command_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_command_line_parser
// Tokenizes a command line byte by byte, tags each byte and reports the
// command, status and key/value positions on the item that ends the line.
// ----------------------------------------------------------------------------
// One item per clock: each byte updates the line state on acceptance and
// its result is captured in an output register at the same time. The
// input stays ready while that register is empty or being drained in the
// same cycle, so a stream of bytes runs at one per clock as long as the
// result side keeps taking items. Bytes past the first 4096 of a line are
// tagged as ignored and the line is reported as too long.
module text_command_line_parser
(
    input  logic        clk,
    input  logic        rst_n,
    tclp_in_if.sink     line_in,
    tclp_out_if.source  result_out
);

    localparam logic [2:0] PH_LEAD  = 3'd0;
    localparam logic [2:0] PH_NAME  = 3'd1;
    localparam logic [2:0] PH_GAP   = 3'd2;
    localparam logic [2:0] PH_KEY   = 3'd3;
    localparam logic [2:0] PH_AFTER = 3'd4;

    localparam int POS_W  = tclp_pkg::POS_W;
    localparam int OFF_W  = tclp_pkg::OFF_W;
    localparam int NUM_KW = tclp_pkg::NUM_KW;
    localparam int OOW    = tclp_pkg::OUT_OFF_W;
    localparam int OLW    = tclp_pkg::OUT_LEN_W;

    logic [2:0]                  phase_reg, phase_next;
    logic [NUM_KW-1:0]           cand_reg, cand_next;
    logic [tclp_pkg::NLEN_W-1:0] nlen_reg, nlen_next;
    logic [POS_W-1:0]            pos_reg, pos_next;
    logic [OFF_W-1:0]            key_begin_reg, key_begin_next;
    logic [POS_W-1:0]            key_count_reg, key_count_next;
    logic [OFF_W-1:0]            value_begin_reg, value_begin_next;
    logic [OFF_W-1:0]            value_last_reg, value_last_next;
    logic                        value_seen_reg, value_seen_next;
    logic                        extra_reg, extra_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg, out_valid_next;
    tclp_pkg::out_item_t         out_data_reg, out_data_next;

    logic                        accept;
    logic [7:0]                  b;
    logic                        ws;
    logic                        take;
    logic [3:0]                  cmd_cur;
    logic                        known;
    logic                        wants_key;
    logic [NUM_KW-1:0]           cand_step;

    logic [2:0]                  ph1;
    logic [NUM_KW-1:0]           cand1;
    logic [NUM_KW-1:0]           cand2;
    logic [tclp_pkg::NLEN_W-1:0] nlen1;
    logic [OFF_W-1:0]            kb1;
    logic [POS_W-1:0]            kc1;
    logic [OFF_W-1:0]            vb1;
    logic [OFF_W-1:0]            vlast1;
    logic                        vseen1;
    logic                        extra1;
    logic                        ovf1;
    logic [1:0]                  role;
    logic [3:0]                  cmd_end;
    logic [POS_W-1:0]            vlen;

    tclp_kw_match u_kw_match
    (
        .cand       (cand_reg),
        .name_len   (nlen_reg),
        .byte_value (line_in.data.byte_value),
        .cand_step  (cand_step)
    );

    assign line_in.ready    = !out_valid_reg || result_out.ready;
    assign accept           = line_in.valid && line_in.ready;
    assign result_out.valid = out_valid_reg;
    assign result_out.data  = out_data_reg;

    assign b         = line_in.data.byte_value;
    assign ws        = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    assign take      = line_in.data.has_byte && (pos_reg < POS_W'(tclp_pkg::MAX_LINE));
    assign cmd_cur   = tclp_pkg::cmd_of(cand_reg);
    assign known     = (cand_reg != '0);
    assign wants_key = known && (cmd_cur <= tclp_pkg::CMD_EXISTS);

    // byte step
    always_comb
    begin
        ph1    = phase_reg;
        cand1  = cand_reg;
        nlen1  = nlen_reg;
        kb1    = key_begin_reg;
        kc1    = key_count_reg;
        vb1    = value_begin_reg;
        vlast1 = value_last_reg;
        vseen1 = value_seen_reg;
        extra1 = extra_reg;
        ovf1   = ovf_reg || (line_in.data.has_byte && !take);
        role   = tclp_pkg::ROLE_NONE;
        if (take)
        begin
            unique case (phase_reg)
                PH_LEAD:
                begin
                    if (!ws)
                    begin
                        ph1   = PH_NAME;
                        cand1 = cand_step;
                        role  = tclp_pkg::ROLE_NAME;
                    end
                end
                PH_NAME:
                begin
                    if (ws)
                    begin
                        cand1 = cand_reg & tclp_pkg::kw_len_mask(nlen_reg);
                        ph1   = PH_GAP;
                    end
                    else
                    begin
                        cand1 = cand_step;
                        role  = tclp_pkg::ROLE_NAME;
                    end
                end
                PH_GAP:
                begin
                    if (!ws && known)
                    begin
                        if (wants_key)
                        begin
                            kb1  = OFF_W'(pos_reg);
                            kc1  = POS_W'(1);
                            ph1  = PH_KEY;
                            role = tclp_pkg::ROLE_KEY;
                        end
                        else
                        begin
                            extra1 = 1'b1;
                        end
                    end
                end
                PH_KEY:
                begin
                    if (ws)
                    begin
                        ph1 = PH_AFTER;
                    end
                    else
                    begin
                        kc1  = key_count_reg + POS_W'(1);
                        role = tclp_pkg::ROLE_KEY;
                    end
                end
                default:
                begin
                    if (cmd_cur == tclp_pkg::CMD_SET)
                    begin
                        if (!ws)
                        begin
                            if (!value_seen_reg)
                            begin
                                vb1 = OFF_W'(pos_reg);
                            end
                            vseen1 = 1'b1;
                            vlast1 = OFF_W'(pos_reg);
                        end
                        if (vseen1)
                        begin
                            role = tclp_pkg::ROLE_VALUE;
                        end
                    end
                    else if (!ws)
                    begin
                        extra1 = 1'b1;
                    end
                end
            endcase
            if ((phase_reg == PH_LEAD && !ws) || (phase_reg == PH_NAME && !ws))
            begin
                if (nlen_reg < 4'd15)
                begin
                    nlen1 = nlen_reg + 4'd1;
                end
            end
        end
    end

    // line outcome and state update
    always_comb
    begin
        cand2   = (ph1 == PH_NAME) ? (cand1 & tclp_pkg::kw_len_mask(nlen1)) : cand1;
        cmd_end = tclp_pkg::cmd_of(cand2);
        vlen    = POS_W'(vlast1) - POS_W'(vb1) + POS_W'(1);

        out_data_next              = '0;
        out_data_next.byte_role    = role;
        out_data_next.byte_offset  = take ? OOW'(pos_reg) : '0;
        out_data_next.line_done    = line_in.data.line_end;

        if (line_in.data.line_end)
        begin
            priority if (ovf1)
            begin
                out_data_next.parse_status = tclp_pkg::ST_TOO_LONG;
            end
            else if (ph1 == PH_LEAD)
            begin
                out_data_next.parse_status = tclp_pkg::ST_EMPTY;
            end
            else if (cand2 == '0)
            begin
                out_data_next.parse_status = tclp_pkg::ST_UNKNOWN;
            end
            else
            begin
                out_data_next.command_code = cmd_end;
                if (cmd_end == tclp_pkg::CMD_SET)
                begin
                    priority if (kc1 == '0)
                    begin
                        out_data_next.parse_status = tclp_pkg::ST_NO_KEY;
                    end
                    else if (!vseen1)
                    begin
                        out_data_next.parse_status = tclp_pkg::ST_NO_VALUE;
                    end
                    else
                    begin
                        out_data_next.key_start    = OOW'(kb1);
                        out_data_next.key_length   = OLW'(kc1);
                        out_data_next.value_start  = OOW'(vb1);
                        out_data_next.value_length = OLW'(vlen);
                    end
                end
                else if (cmd_end <= tclp_pkg::CMD_EXISTS)
                begin
                    priority if (kc1 == '0)
                    begin
                        out_data_next.parse_status = tclp_pkg::ST_NO_KEY;
                    end
                    else if (extra1)
                    begin
                        out_data_next.parse_status = tclp_pkg::ST_EXTRA;
                    end
                    else
                    begin
                        out_data_next.key_start  = OOW'(kb1);
                        out_data_next.key_length = OLW'(kc1);
                    end
                end
                else if (extra1)
                begin
                    out_data_next.parse_status = tclp_pkg::ST_EXTRA;
                end
            end
        end

        if (line_in.data.line_end)
        begin
            phase_next       = PH_LEAD;
            cand_next        = tclp_pkg::ALL_KW;
            nlen_next        = '0;
            pos_next         = '0;
            key_begin_next   = '0;
            key_count_next   = '0;
            value_begin_next = '0;
            value_last_next  = '0;
            value_seen_next  = 1'b0;
            extra_next       = 1'b0;
            ovf_next         = 1'b0;
        end
        else
        begin
            phase_next       = ph1;
            cand_next        = cand1;
            nlen_next        = nlen1;
            pos_next         = take ? pos_reg + POS_W'(1) : pos_reg;
            key_begin_next   = kb1;
            key_count_next   = kc1;
            value_begin_next = vb1;
            value_last_next  = vlast1;
            value_seen_next  = vseen1;
            extra_next       = extra1;
            ovf_next         = ovf1;
        end

        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_LEAD;
            cand_reg        <= tclp_pkg::ALL_KW;
            nlen_reg        <= '0;
            pos_reg         <= '0;
            key_begin_reg   <= '0;
            key_count_reg   <= '0;
            value_begin_reg <= '0;
            value_last_reg  <= '0;
            value_seen_reg  <= 1'b0;
            extra_reg       <= 1'b0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg       <= phase_next;
                cand_reg        <= cand_next;
                nlen_reg        <= nlen_next;
                pos_reg         <= pos_next;
                key_begin_reg   <= key_begin_next;
                key_count_reg   <= key_count_next;
                value_begin_reg <= value_begin_next;
                value_last_reg  <= value_last_next;
                value_seen_reg  <= value_seen_next;
                extra_reg       <= extra_next;
                ovf_reg         <= ovf_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_line_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && line_in.data.line_end |=>
            phase_reg == PH_LEAD && cand_reg == tclp_pkg::ALL_KW && pos_reg == '0)
        else $error("line state not cleared after line end");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_W'(tclp_pkg::MAX_LINE))
        else $error("line position beyond maximum");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted item left no result");

    a_mid_line_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.line_done |->
            out_data_reg.parse_status == tclp_pkg::ST_OK &&
            out_data_reg.command_code == tclp_pkg::CMD_SET &&
            out_data_reg.key_length == '0)
        else $error("outcome fields set before line end");

    a_set_value_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.line_done &&
        out_data_reg.parse_status == tclp_pkg::ST_OK &&
        out_data_reg.command_code == tclp_pkg::CMD_SET |->
            out_data_reg.value_length != '0 && out_data_reg.key_length != '0)
        else $error("accepted set command without key or value");
`endif

endmodule

@@ tb/tb_text_command_line_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_command_line_parser
// Self-checking bench for the command line parser. Each accepted input item
// runs through a bit-level model of the tokenizer and keyword matcher kept
// here. The matching result item is compared field by field in order. A
// table of directed lines comes first (edge whitespace, every keyword, each
// error status, lines at and past the length limit). Random command lines
// follow, mostly well formed. Bursty input and a stalling result side are
// used throughout.
// ----------------------------------------------------------------------------
module tb_text_command_line_parser;
    import tclp_pkg::*;

    typedef enum logic [2:0] {SCAN_LEAD, SCAN_NAME, SCAN_GAP, SCAN_KEY, SCAN_TAIL} scan_phase_e;

    typedef struct packed {
        in_item_t  it;
        logic      typed;
        out_item_t outcome;
    } stim_t;

    typedef struct packed {
        logic [191:0] text;
        logic [12:0]  pad_n;
        logic [7:0]   pad_c;
        logic         bare;
        logic [1:0]   mid;
        logic         typed;
        logic [3:0]   cmd;
        logic [2:0]   st;
        logic [11:0]  ks;
        logic [12:0]  kl;
        logic [11:0]  vs;
        logic [12:0]  vl;
    } row_t;

    localparam int NUM_ROWS = 27;
    localparam int HALF_RANDOM = 825;

    localparam row_t DIRECTED [NUM_ROWS] = '{
        '{192'(""), 13'd0, 8'h00, 1'b1, 2'd0, 1'b1,
          CMD_SET, ST_EMPTY, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'(" \011\012\013\014\015"), 13'd0, 8'h00, 1'b1, 2'd0, 1'b1,
          CMD_SET, ST_EMPTY, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("SET key value"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_OK, 12'd4, 13'd3, 12'd8, 13'd5},
        '{192'("set  k   a b  \011"), 13'd0, 8'h00, 1'b1, 2'd0, 1'b1,
          CMD_SET, ST_OK, 12'd5, 13'd1, 12'd9, 13'd3},
        '{192'("SET"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_NO_KEY, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("sEt k   "), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_NO_VALUE, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("GeT abc"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_GET, ST_OK, 12'd4, 13'd3, 12'd0, 13'd0},
        '{192'("get a b"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_GET, ST_EXTRA, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("DELETE x"), 13'd0, 8'h00, 1'b1, 2'd0, 1'b1,
          CMD_DELETE, ST_OK, 12'd7, 13'd1, 12'd0, 13'd0},
        '{192'("exists"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_EXISTS, ST_NO_KEY, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("KEYS"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_KEYS, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("clear x"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_CLEAR, ST_EXTRA, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("\011Begin "), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_BEGIN, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("COMMIT"), 13'd0, 8'h00, 1'b1, 2'd0, 1'b1,
          CMD_COMMIT, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("RollBack"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_ROLLBACK, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("help"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_HELP, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("EXIT \013"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_EXIT, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("sets x"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_UNKNOWN, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("se"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_UNKNOWN, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("\305et k v"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_UNKNOWN, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("rollbackrollback"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_UNKNOWN, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("GET k"), 13'd0, 8'h00, 1'b0, 2'd2, 1'b1,
          CMD_GET, ST_OK, 12'd4, 13'd1, 12'd0, 13'd0},
        '{192'("SET \377 \200 \177"), 13'd0, 8'h00, 1'b0, 2'd0, 1'b0,
          CMD_SET, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("exists  Key\011"), 13'd0, 8'h00, 1'b1, 2'd1, 1'b0,
          CMD_SET, ST_OK, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'("SET k "), 13'd4090, 8'h76, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_OK, 12'd4, 13'd1, 12'd6, 13'd4090},
        '{192'("GET k"), 13'd4092, 8'h7A, 1'b0, 2'd0, 1'b1,
          CMD_SET, ST_TOO_LONG, 12'd0, 13'd0, 12'd0, 13'd0},
        '{192'(""), 13'd4097, 8'h20, 1'b1, 2'd0, 1'b1,
          CMD_SET, ST_TOO_LONG, 12'd0, 13'd0, 12'd0, 13'd0}
    };

    // index equals command code
    string kw_word [NUM_KW] = '{"set", "get", "delete", "exists", "keys", "clear",
                                "begin", "commit", "rollback", "help", "exit"};

    logic clk;
    logic rst_n;

    tclp_in_if  line_ch ();
    tclp_out_if result_ch ();

    text_command_line_parser dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_in    (line_ch),
        .result_out (result_ch)
    );

    scan_phase_e       scan_phase;
    logic [NUM_KW-1:0] kw_alive;
    logic [3:0]        name_len;
    logic [12:0]       line_pos;
    logic [11:0]       key_at;
    logic [12:0]       key_len;
    logic [11:0]       val_at;
    logic [11:0]       val_last;
    logic              val_seen;
    logic              extra_seen;
    logic              overflow;

    out_item_t  outcomes_due [$];
    stim_t      stim_q [$];
    logic [7:0] line_bytes [$];
    int         mismatches = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic logic is_blank(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic logic [7:0] lower(logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
    endfunction

    function automatic logic [3:0] first_kw(logic [NUM_KW-1:0] m);
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (m[k])
            begin
                return 4'(k);
            end
        end
        return CMD_SET;
    endfunction

    function automatic void clear_line();
        scan_phase = SCAN_LEAD;
        kw_alive   = ALL_KW;
        name_len   = '0;
        line_pos   = '0;
        key_at     = '0;
        key_len    = '0;
        val_at     = '0;
        val_last   = '0;
        val_seen   = 1'b0;
        extra_seen = 1'b0;
        overflow   = 1'b0;
    endfunction

    function automatic void match_name(logic [7:0] b);
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (kw_alive[k] && (int'(name_len) >= kw_word[k].len() ||
                kw_word[k][int'(name_len)] != lower(b)))
            begin
                kw_alive[k] = 1'b0;
            end
        end
        if (name_len < 4'd15)
        begin
            name_len++;
        end
    endfunction

    function automatic void close_name();
        for (int k = 0; k < NUM_KW; k++)
        begin
            if (kw_word[k].len() != int'(name_len))
            begin
                kw_alive[k] = 1'b0;
            end
        end
        scan_phase = SCAN_GAP;
    endfunction

    function automatic logic [1:0] scan_byte(logic [7:0] b);
        logic       ws;
        logic [3:0] cmd;
        logic       known;
        logic [1:0] role;
        ws    = is_blank(b);
        cmd   = first_kw(kw_alive);
        known = (kw_alive != '0);
        role  = ROLE_NONE;
        case (scan_phase)
            SCAN_LEAD:
            begin
                if (!ws)
                begin
                    scan_phase = SCAN_NAME;
                    match_name(b);
                    role = ROLE_NAME;
                end
            end
            SCAN_NAME:
            begin
                if (ws)
                begin
                    close_name();
                end
                else
                begin
                    match_name(b);
                    role = ROLE_NAME;
                end
            end
            SCAN_GAP:
            begin
                if (!ws && known)
                begin
                    if (cmd <= CMD_EXISTS)
                    begin
                        key_at     = line_pos[11:0];
                        key_len    = 13'd1;
                        scan_phase = SCAN_KEY;
                        role       = ROLE_KEY;
                    end
                    else
                    begin
                        extra_seen = 1'b1;
                    end
                end
            end
            SCAN_KEY:
            begin
                if (ws)
                begin
                    scan_phase = SCAN_TAIL;
                end
                else
                begin
                    key_len++;
                    role = ROLE_KEY;
                end
            end
            default:
            begin
                if (cmd == CMD_SET)
                begin
                    if (!ws)
                    begin
                        if (!val_seen)
                        begin
                            val_at = line_pos[11:0];
                        end
                        val_seen = 1'b1;
                        val_last = line_pos[11:0];
                    end
                    if (val_seen)
                    begin
                        role = ROLE_VALUE;
                    end
                end
                else if (!ws)
                begin
                    extra_seen = 1'b1;
                end
            end
        endcase
        line_pos++;
        return role;
    endfunction

    function automatic out_item_t parse_item(in_item_t it);
        out_item_t  o;
        logic [3:0] cmd;
        o = '0;
        if (it.has_byte)
        begin
            if (line_pos >= MAX_LINE)
            begin
                overflow = 1'b1;
            end
            else
            begin
                o.byte_offset = line_pos[11:0];
                o.byte_role   = scan_byte(it.byte_value);
            end
        end
        if (it.line_end)
        begin
            o.line_done = 1'b1;
            if (scan_phase == SCAN_NAME)
            begin
                close_name();
            end
            if (overflow)
            begin
                o.parse_status = ST_TOO_LONG;
            end
            else if (scan_phase == SCAN_LEAD)
            begin
                o.parse_status = ST_EMPTY;
            end
            else if (kw_alive == '0)
            begin
                o.parse_status = ST_UNKNOWN;
            end
            else
            begin
                cmd = first_kw(kw_alive);
                o.command_code = cmd;
                if (cmd == CMD_SET)
                begin
                    if (key_len == '0)
                    begin
                        o.parse_status = ST_NO_KEY;
                    end
                    else if (!val_seen)
                    begin
                        o.parse_status = ST_NO_VALUE;
                    end
                    else
                    begin
                        o.key_start    = key_at;
                        o.key_length   = key_len;
                        o.value_start  = val_at;
                        o.value_length = {1'b0, val_last - val_at} + 13'd1;
                    end
                end
                else if (cmd <= CMD_EXISTS)
                begin
                    if (key_len == '0)
                    begin
                        o.parse_status = ST_NO_KEY;
                    end
                    else if (extra_seen)
                    begin
                        o.parse_status = ST_EXTRA;
                    end
                    else
                    begin
                        o.key_start  = key_at;
                        o.key_length = key_len;
                    end
                end
                else if (extra_seen)
                begin
                    o.parse_status = ST_EXTRA;
                end
            end
            clear_line();
        end
        return o;
    endfunction

    function automatic stim_t idle_item(logic line_end);
        stim_t s;
        s = '0;
        s.it.byte_value = 8'($urandom_range(0, 255));
        s.it.line_end   = line_end;
        return s;
    endfunction

    // turns line_bytes into byte items and closes the line
    task automatic flush_line(int mid_first, logic rand_mid, logic bare, logic typed,
                              out_item_t outcome);
        stim_t s;
        int    n;
        n = line_bytes.size();
        for (int i = 0; i < n; i++)
        begin
            s = '0;
            s.it.byte_value = line_bytes[i];
            s.it.has_byte   = 1'b1;
            s.it.line_end   = (i == n - 1) && !bare;
            if (s.it.line_end)
            begin
                s.typed   = typed;
                s.outcome = outcome;
            end
            stim_q.push_back(s);
            if (i == 0)
            begin
                repeat (mid_first) stim_q.push_back(idle_item(1'b0));
            end
            if (rand_mid && i != n - 1 && $urandom_range(0, 15) == 0)
            begin
                stim_q.push_back(idle_item(1'b0));
            end
        end
        if (bare || n == 0)
        begin
            s = idle_item(1'b1);
            s.typed   = typed;
            s.outcome = outcome;
            stim_q.push_back(s);
        end
        line_bytes.delete();
    endtask

    function automatic logic [7:0] ws_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 0) ? 8'h20 : 8'(8 + r);
    endfunction

    function automatic logic [7:0] solid_byte();
        logic [7:0] b;
        case ($urandom_range(0, 3))
            0:       b = 8'($urandom_range(0, 255));
            1:       b = 8'h41 + 8'($urandom_range(0, 25));
            default: b = 8'h61 + 8'($urandom_range(0, 25));
        endcase
        if (is_blank(b))
        begin
            b = 8'h5F;
        end
        return b;
    endfunction

    task automatic put_ws(int lo, int hi);
        repeat ($urandom_range(lo, hi)) line_bytes.push_back(ws_byte());
    endtask

    task automatic put_token(int lo, int hi);
        repeat ($urandom_range(lo, hi)) line_bytes.push_back(solid_byte());
    endtask

    task automatic put_word(string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++)
        begin
            c = w[i];
            if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
            begin
                c = c - 8'h20;
            end
            line_bytes.push_back(c);
        end
    endtask

    task automatic add_random_line();
        int kind;
        int k;
        int words;
        kind = $urandom_range(0, 15);
        k    = $urandom_range(0, NUM_KW - 1);
        if (kind < 11)
        begin
            put_ws(0, 2);
            put_word(kw_word[k]);
            if (k <= int'(CMD_EXISTS) && $urandom_range(0, 7) != 0)
            begin
                put_ws(1, 3);
                put_token(1, 6);
            end
            if (k == int'(CMD_SET) && $urandom_range(0, 7) != 0)
            begin
                words = $urandom_range(1, 3);
                for (int w = 0; w < words; w++)
                begin
                    put_ws(1, 3);
                    put_token(1, 5);
                end
            end
            if ($urandom_range(0, 7) == 0)
            begin
                put_ws(1, 2);
                put_token(1, 4);
            end
            put_ws(0, 2);
        end
        else if (kind == 11)
        begin
            repeat ($urandom_range(0, 20)) line_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind == 12)
        begin
            case ($urandom_range(0, 2))
                0: put_word(kw_word[k].substr(0, kw_word[k].len() - 2));
                1:
                begin
                    put_word(kw_word[k]);
                    line_bytes.push_back(solid_byte());
                end
                default:
                begin
                    put_word(kw_word[k]);
                    line_bytes[$urandom_range(0, line_bytes.size() - 1)] = solid_byte();
                end
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                put_ws(1, 2);
                put_token(1, 5);
            end
        end
        else if (kind == 13)
        begin
            put_ws(0, 4);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
            begin
                put_ws(0, 2);
                put_token(1, 8);
            end
        end
        flush_line(0, 1'b1, $urandom_range(0, 2) == 0, 1'b0, '0);
    endtask

    task automatic send_all();
        stim_t     s;
        out_item_t o;
        int        burst_left;
        int        gap;
        burst_left = 0;
        while (stim_q.size() != 0)
        begin
            s = stim_q.pop_front();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    line_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            burst_left--;
            line_ch.valid <= 1'b1;
            line_ch.data  <= s.it;
            @(posedge clk);
            while (!line_ch.ready)
            begin
                @(posedge clk);
            end
            o = parse_item(s.it);
            if (s.typed)
            begin
                s.outcome.byte_role   = o.byte_role;
                s.outcome.byte_offset = o.byte_offset;
                s.outcome.line_done   = 1'b1;
                o = s.outcome;
            end
            outcomes_due.push_back(o);
            @(negedge clk);
        end
        line_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (outcomes_due.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        out_item_t t;
        rst_n         = 1'b0;
        line_ch.valid = 1'b0;
        line_ch.data  = '0;
        clear_line();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < NUM_ROWS; r++)
        begin
            for (int i = 23; i >= 0; i--)
            begin
                if (DIRECTED[r].text[i*8 +: 8] != 8'h00)
                begin
                    line_bytes.push_back(DIRECTED[r].text[i*8 +: 8]);
                end
            end
            repeat (int'(DIRECTED[r].pad_n)) line_bytes.push_back(DIRECTED[r].pad_c);
            t = '0;
            t.command_code = DIRECTED[r].cmd;
            t.parse_status = DIRECTED[r].st;
            t.key_start    = DIRECTED[r].ks;
            t.key_length   = DIRECTED[r].kl;
            t.value_start  = DIRECTED[r].vs;
            t.value_length = DIRECTED[r].vl;
            flush_line(int'(DIRECTED[r].mid), 1'b0, DIRECTED[r].bare, DIRECTED[r].typed, t);
        end
        send_all();
        wait_drained();

        repeat (2)
        begin
            while (stim_q.size() < HALF_RANDOM)
            begin
                add_random_line();
            end
            send_all();
            wait_drained();
        end

        repeat (8) @(negedge clk);
        if (mismatches == 0 && outcomes_due.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    // result side: stall patterns, switched among four modes at random
    initial
    begin
        int mode;
        int left;
        int tick;
        result_ch.ready = 1'b0;
        mode = 0;
        left = 0;
        tick = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 300);
            end
            left--;
            tick++;
            case (mode)
                0:       result_ch.ready <= 1'b1;
                1:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                2:       result_ch.ready <= ($urandom_range(0, 3) == 0);
                default: result_ch.ready <= ((tick % 7) < 4);
            endcase
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $error("result item with no outcome due");
                mismatches++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                got  = result_ch.data;
                check_field("byte_role", 16'(want.byte_role), 16'(got.byte_role));
                check_field("byte_offset", 16'(want.byte_offset), 16'(got.byte_offset));
                check_field("line_done", 16'(want.line_done), 16'(got.line_done));
                check_field("command_code", 16'(want.command_code), 16'(got.command_code));
                check_field("parse_status", 16'(want.parse_status), 16'(got.parse_status));
                check_field("key_start", 16'(want.key_start), 16'(got.key_start));
                check_field("key_length", 16'(want.key_length), 16'(got.key_length));
                check_field("value_start", 16'(want.value_start), 16'(got.value_start));
                check_field("value_length", 16'(want.value_length), 16'(got.value_length));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

@@ text_command_line_parser.f @@
hw/rtl/tclp_pkg.sv
hw/rtl/tclp_in_if.sv
hw/rtl/tclp_out_if.sv
hw/rtl/tclp_kw_match.sv
hw/rtl/text_command_line_parser.sv
tb/tb_text_command_line_parser.sv
